### rtl/core/gsbc_pkg.sv
// gsbc_pkg: shared types, register indexes and the sequencer microcode table
// for the gas sensor baseline calibrator. Depends on nothing.
`default_nettype none

package gsbc_pkg;

  // payload words
  typedef struct packed {
    logic [14:0] raw_sample;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [31:0] baseline_resistance;
    logic [9:0]  kept_count;
  } out_word_t;

  // configuration register indexes
  localparam logic [2:0] CFG_RAW_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_SUPPLY_COUNTS   = 3'd1;
  localparam logic [2:0] CFG_LOAD_RESISTANCE = 3'd2;
  localparam logic [2:0] CFG_CLEAN_AIR_RATIO = 3'd3;
  localparam logic [2:0] CFG_RATIO_LIMIT     = 3'd4;
  localparam logic [2:0] CFG_MIN_VALID       = 3'd5;

  localparam int unsigned DIV_WIDTH = 48;
  localparam int unsigned DEN_WIDTH = 24;
  localparam int unsigned DIV_CNT_WIDTH = $clog2(DIV_WIDTH);

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] BASELINE_RESET = 32'd655360;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MUL,
    OP_LOAD_RS,
    OP_DIV_STEP,
    OP_LOAD_RATIO,
    OP_ACCUM,
    OP_LOAD_BASE,
    OP_SET_BASE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SKIP,
    COND_DIV_BUSY,
    COND_QUO_ZERO,
    COND_NOT_LAST,
    COND_TOO_FEW,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_WAIT       = 4'd0;
  localparam step_t STEP_MUL        = 4'd1;
  localparam step_t STEP_LOAD_RS    = 4'd2;
  localparam step_t STEP_DIV_RS     = 4'd3;
  localparam step_t STEP_LOAD_RATIO = 4'd4;
  localparam step_t STEP_DIV_RATIO  = 4'd5;
  localparam step_t STEP_ACCUM      = 4'd6;
  localparam step_t STEP_END        = 4'd7;
  localparam step_t STEP_LOAD_BASE  = 4'd8;
  localparam step_t STEP_DIV_BASE   = 4'd9;
  localparam step_t STEP_SET_BASE   = 4'd10;
  localparam step_t STEP_EMIT       = 4'd11;
  localparam step_t STEP_RET        = 4'd12;

  // jump to target when cond holds, else fall through to the next step
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic ctrl_t ctrl_rom(input step_t pc);
    ctrl_t w;
    case (pc)
      STEP_WAIT:       w = '{OP_ACCEPT,     COND_NO_INPUT, STEP_WAIT};
      STEP_MUL:        w = '{OP_MUL,        COND_SKIP,     STEP_END};
      STEP_LOAD_RS:    w = '{OP_LOAD_RS,    COND_NEVER,    STEP_WAIT};
      STEP_DIV_RS:     w = '{OP_DIV_STEP,   COND_DIV_BUSY, STEP_DIV_RS};
      STEP_LOAD_RATIO: w = '{OP_LOAD_RATIO, COND_QUO_ZERO, STEP_END};
      STEP_DIV_RATIO:  w = '{OP_DIV_STEP,   COND_DIV_BUSY, STEP_DIV_RATIO};
      STEP_ACCUM:      w = '{OP_ACCUM,      COND_NEVER,    STEP_WAIT};
      STEP_END:        w = '{OP_NONE,       COND_NOT_LAST, STEP_WAIT};
      STEP_LOAD_BASE:  w = '{OP_LOAD_BASE,  COND_TOO_FEW,  STEP_EMIT};
      STEP_DIV_BASE:   w = '{OP_DIV_STEP,   COND_DIV_BUSY, STEP_DIV_BASE};
      STEP_SET_BASE:   w = '{OP_SET_BASE,   COND_NEVER,    STEP_WAIT};
      STEP_EMIT:       w = '{OP_EMIT,       COND_OUT_BUSY, STEP_EMIT};
      STEP_RET:        w = '{OP_NONE,       COND_ALWAYS,   STEP_WAIT};
      default:         w = '{OP_NONE,       COND_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sat32(input logic [47:0] v);
    return (v[47:32] != 16'd0) ? U32_MAX : v[31:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/gas_sensor_baseline_calibrator.sv
// gas_sensor_baseline_calibrator: microcoded sequencer over a multiplier and one
// shared divider. One word at a time: both divisions run unless the threshold or
// supply check drops the sample (no division) or rs truncates to zero (rs only).
// A last sample then adds averaging and the result word, or only the result word
// with too few samples; the result word waits out any output stall.
// Synchronous reset loads the default registers, baseline 10.0, clears sum and count.
`default_nettype none

module gas_sensor_baseline_calibrator
  import gsbc_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 512
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word
);

  localparam logic [9:0] CountCap = (MAX_SAMPLES > 1023) ? 10'd1023 : 10'(MAX_SAMPLES);

  // configuration
  logic [14:0] raw_threshold;
  logic [16:0] supply_counts;
  logic [23:0] load_resistance;
  logic [23:0] clean_air_ratio;
  logic [31:0] ratio_limit;
  logic [9:0]  min_valid;

  // sequencer and datapath
  step_t       pc;
  step_t       pc_next;
  ctrl_t       ctrl;
  logic        cond_true;
  logic [14:0] raw;
  logic        last;
  logic [40:0] prod;
  logic [31:0] baseline;
  logic [47:0] ratio_sum;
  logic [9:0]  kept;
  logic        few;
  logic        skip;
  logic        too_few;
  logic        out_busy;
  logic        emit_fire;
  logic        accept;

  div_ctrl_t              div_ctrl;
  logic [DIV_WIDTH-1:0]   div_dividend;
  logic [DEN_WIDTH-1:0]   div_divisor;
  logic [DIV_WIDTH-1:0]   div_quo;
  logic                   div_busy;

  logic [31:0] rs_sat;
  logic [31:0] ratio;
  logic        keep;
  logic [48:0] sum_add;

  gsbc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_threshold   <= 15'd100;
      supply_counts   <= 17'd49647;
      load_resistance <= 24'd655360;
      clean_air_ratio <= 24'd235930;
      ratio_limit     <= 32'd65536000;
      min_valid       <= 10'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAW_THRESHOLD:   raw_threshold   <= cfg_data[14:0];
        CFG_SUPPLY_COUNTS:   supply_counts   <= cfg_data[16:0];
        CFG_LOAD_RESISTANCE: load_resistance <= cfg_data[23:0];
        CFG_CLEAN_AIR_RATIO: clean_air_ratio <= cfg_data[23:0];
        CFG_RATIO_LIMIT:     ratio_limit     <= cfg_data;
        CFG_MIN_VALID:       min_valid       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign ctrl = ctrl_rom(pc);

  always_comb begin
    skip     = (raw <= raw_threshold) || (raw == 15'd0) || ({2'b00, raw} >= supply_counts);
    too_few  = (kept <= min_valid) || (kept == 10'd0);
    out_busy = out_valid && out_stall;
    rs_sat   = sat32(div_quo);
    ratio    = (clean_air_ratio == 24'd0) ? U32_MAX : sat32(div_quo);
    keep     = (ratio != 32'd0) && (ratio < ratio_limit) && (kept < CountCap);
    sum_add  = {1'b0, ratio_sum} + {17'd0, ratio};
  end

  // next step
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_INPUT: cond_true = !in_valid;
      COND_SKIP:     cond_true = skip;
      COND_DIV_BUSY: cond_true = div_busy;
      COND_QUO_ZERO: cond_true = div_quo == '0;
      COND_NOT_LAST: cond_true = !last;
      COND_TOO_FEW:  cond_true = too_few;
      COND_OUT_BUSY: cond_true = out_busy;
      default:       cond_true = 1'b1;
    endcase
    pc_next = cond_true ? ctrl.target : pc + 1'b1;
  end

  // datapath controls
  always_comb begin
    in_stall      = ctrl.op != OP_ACCEPT;
    accept        = (ctrl.op == OP_ACCEPT) && in_valid;
    emit_fire     = (ctrl.op == OP_EMIT) && !out_busy;
    div_ctrl.load = 1'b0;
    div_ctrl.step = ctrl.op == OP_DIV_STEP;
    div_dividend  = {7'd0, prod};
    div_divisor   = {9'd0, raw};
    case (ctrl.op)
      OP_LOAD_RS: begin
        div_ctrl.load = 1'b1;
      end
      OP_LOAD_RATIO: begin
        div_ctrl.load = 1'b1;
        div_dividend  = {rs_sat, 16'd0};
        div_divisor   = clean_air_ratio;
      end
      OP_LOAD_BASE: begin
        div_ctrl.load = !too_few;
        div_dividend  = ratio_sum;
        div_divisor   = {14'd0, kept};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw  <= in_word.raw_sample;
      last <= in_word.last;
    end
    if (ctrl.op == OP_MUL) begin
      prod <= {17'd0, load_resistance} * {24'd0, supply_counts - {2'b00, raw}};
    end
    if (ctrl.op == OP_LOAD_BASE) begin
      few <= too_few;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline  <= BASELINE_RESET;
      ratio_sum <= '0;
      kept      <= '0;
    end else begin
      if (ctrl.op == OP_ACCUM && keep) begin
        ratio_sum <= sum_add[48] ? SUM_MAX : sum_add[47:0];
        kept      <= kept + 1'b1;
      end
      if (ctrl.op == OP_SET_BASE) begin
        baseline <= sat32(div_quo);
      end
      if (emit_fire) begin
        ratio_sum <= '0;
        kept      <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_word.status              <= few;
      out_word.baseline_resistance <= baseline;
      out_word.kept_count          <= kept;
    end
  end

  // assertions
  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result word appeared outside the emit step");

  a_kept_capped: assert property (@(posedge clk) disable iff (rst)
    kept <= CountCap)
    else $error("kept count above cap");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on two cycles in a row");

  a_status_ok_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.status) |-> (out_word.kept_count > min_valid))
    else $error("baseline updated with too few samples");

endmodule

`default_nettype wire

### rtl/core/gsbc_divider.sv
// gsbc_divider: restoring divider, one quotient bit per cycle while
// step is high, 48-bit dividend by 24-bit divisor. Depends on gsbc_pkg.
`default_nettype none

module gsbc_divider
  import gsbc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire div_ctrl_t              ctrl,
  input  wire logic [DIV_WIDTH-1:0]   dividend,
  input  wire logic [DEN_WIDTH-1:0]   divisor,
  output logic      [DIV_WIDTH-1:0]   quotient,
  output logic                        busy
);

  logic [DIV_CNT_WIDTH-1:0] cnt;
  logic [DEN_WIDTH-1:0]     den;
  logic [DEN_WIDTH-1:0]     rem;
  logic [DIV_WIDTH-1:0]     quo;
  logic [DEN_WIDTH:0]       rem_sh;
  logic                     fits;

  always_comb begin
    rem_sh = {rem, quo[DIV_WIDTH-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= DIV_CNT_WIDTH'(DIV_WIDTH - 1);
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (ctrl.step) begin
      // quotient bits shift in from the bottom as the dividend shifts out
      quo <= {quo[DIV_WIDTH-2:0], fits};
      rem <= fits ? DEN_WIDTH'(rem_sh - {1'b0, den}) : rem_sh[DEN_WIDTH-1:0];
    end
  end

  assign quotient = quo;
  assign busy     = cnt != '0;

endmodule

`default_nettype wire
